[src/lsac_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lsac_pkg;

    // Ring and word geometry
    localparam int WINDOW_DEPTH = 8;
    localparam int RAW_W        = 10;
    localparam int RAW_COUNT    = 1 << RAW_W;
    localparam int LUX_W        = 20;
    localparam int LIMIT_W      = 16;
    localparam int FRAC_W       = 4;
    localparam int SLOT_W       = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W        = LUX_W + $clog2(WINDOW_DEPTH);
    localparam int STEP_W       = $clog2(SUM_W);
    localparam int STATUS_W     = 2;
    localparam int IN_TDATA_W   = 16;
    localparam int OUT_TDATA_W  = 48;
    localparam int OUT_PAD_W    = OUT_TDATA_W - 2 * LUX_W - STATUS_W;
    localparam int CFG_ADDR_W   = 1;

    // Conversion constants
    localparam longint unsigned LUX_SCALE = 64'd48200;
    localparam longint unsigned EXP_NUM   = 64'd153;
    localparam longint unsigned EXP_DEN   = 64'd100;
    localparam logic [LUX_W-1:0] LUX_MAX  = {LUX_W{1'b1}};

    // Configuration register indexes and reset values
    localparam logic [CFG_ADDR_W-1:0] CFG_LOW_LIMIT  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_HIGH_LIMIT = 1'b1;
    localparam logic [LIMIT_W-1:0]    LOW_LIMIT_RST  = 16'd100;
    localparam logic [LIMIT_W-1:0]    HIGH_LIMIT_RST = 16'd700;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_GOOD = 2'd0,
        STATUS_POOR = 2'd1,
        STATUS_HIGH = 2'd2
    } t_status;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;    // capture sample, look up lux, read old ring entry
        logic update;    // update ring, sum and count, load divider
        logic div_step;  // one quotient bit
        logic out_load;  // classify and load output register
    } t_ctrl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;  // output register can take a word this cycle
    } t_dp_status;

    typedef logic [LUX_W-1:0] t_lux_rom [RAW_COUNT];

    // Integer square root, bit by bit
    function automatic longint unsigned isqrt64(input longint unsigned v_in);
        longint unsigned v;
        longint unsigned r;
        longint unsigned b;
        v = v_in;
        r = 64'd0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (b > v) b = b >> 2;
        end
        for (int i = 0; i < 32; i++) begin
            if (b != 64'd0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // Lux of one reading: LUX_SCALE * raw^(-1.53) in Q.4
    function automatic logic [LUX_W-1:0] raw_to_lux(input int unsigned raw);
        longint unsigned one;
        longint unsigned n;
        longint unsigned x;
        longint unsigned frac;
        longint unsigned lg;
        longint unsigned e;
        longint unsigned ip;
        longint unsigned fp;
        longint unsigned m;
        longint unsigned c;
        longint unsigned prod;
        longint unsigned sh;
        longint unsigned y;
        one  = 64'd1 << 30;
        n    = 64'd0;
        frac = 64'd0;
        if (raw == 0) return LUX_MAX;
        for (int i = 0; i < 9; i++) begin
            if ((longint'(raw) >> (n + 1)) != 0) n = n + 1;
        end
        x = longint'(raw) << (30 - n);
        // fraction of log2 by repeated squaring
        for (int k = 0; k < 16; k++) begin
            x    = (x * x) >> 30;
            frac = frac << 1;
            if (x >= 2 * one) begin
                frac = frac | 64'd1;
                x    = x >> 1;
            end
        end
        lg = (n << 16) | frac;
        e  = (lg * EXP_NUM + EXP_DEN / 2) / EXP_DEN;
        ip = e >> 16;
        fp = e & 64'hFFFF;
        // 2^-fp as a product of 2^(-2^-k) factors
        m = one;
        c = isqrt64(64'd1 << 59);
        for (int k = 1; k <= 16; k++) begin
            if (((fp >> (16 - k)) & 64'd1) != 0)
                m = (m * c + (64'd1 << 29)) >> 30;
            c = isqrt64(c << 30);
        end
        if (ip > 30) return '0;
        prod = LUX_SCALE * 64'd16 * m;
        sh   = 30 + ip;
        y    = (prod + (64'd1 << (sh - 1))) >> sh;
        if (y > longint'(LUX_MAX)) return LUX_MAX;
        return y[LUX_W-1:0];
    endfunction

    function automatic t_lux_rom build_lux_rom();
        t_lux_rom rom;
        for (int i = 0; i < RAW_COUNT; i++) begin
            rom[i] = raw_to_lux(i);
        end
        return rom;
    endfunction

    localparam t_lux_rom LUX_ROM = build_lux_rom();

endpackage

`default_nettype wire

[src/light_sensor_average_classifier_core.sv]
// Light sensor averaging classifier.
// Input stream (s_axis): one word per converter reading, tdata[9:0] raw sample.
// Output stream (m_axis): one word per reading: current lux, mean lux over
// the filled ring entries and a good/poor/high status, lux in Q.4.
// Configuration: write i_cfg_wdata to register i_cfg_addr while i_cfg_we is
// high (0 low limit, 1 high limit, whole lux); only while the block is idle.
// Timing: a reading is accepted, converted through a 1024-entry lux ROM and
// added to the ring in the next cycle, then the mean comes out of a serial
// restoring divider, one quotient bit per cycle over the 23-bit sum. The
// result word becomes valid when it is loaded into the output register, and
// s_axis_tready returns in the same cycle, so no new reading is accepted
// until the divider has finished and the result word is loaded.
// Stall: the result sits in an output register; a new reading is accepted
// while it waits, and the block holds in its last step until the register
// is free.
// Reset (synchronous, active low): ring empty, running sum zero, limits
// back to 100 and 700 lux, output empty.
`timescale 1ns / 1ps
`default_nettype none

module light_sensor_average_classifier_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // tdata: raw_sample[9:0], zero pad [15:10]
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [lsac_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // tdata: current_lux[19:0], average_lux[39:20], light_status[41:40], pad
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [lsac_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    input  wire logic                                i_cfg_we,
    input  wire logic [lsac_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  wire logic [lsac_pkg::LIMIT_W-1:0]        i_cfg_wdata
);
    import lsac_pkg::*;

    t_ctrl_cmd         cmd;
    t_dp_status        status;
    logic [LUX_W-1:0]  current_lux;
    logic [LUX_W-1:0]  average_lux;
    logic [STATUS_W-1:0] light_status;

    lsac_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    lsac_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_raw_sample   (s_axis_tdata[RAW_W-1:0]),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_current_lux  (current_lux),
        .o_average_lux  (average_lux),
        .o_light_status (light_status)
    );

    // Pack result word, first field lowest
    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, light_status, average_lux, current_lux};

endmodule

`default_nettype wire

[src/lsac_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module lsac_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire lsac_pkg::t_dp_status i_status,
    output lsac_pkg::t_ctrl_cmd      o_cmd
);
    import lsac_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_FINISH
    } t_state;

    t_state            r_state, n_state;
    logic              r_ready, n_ready;
    logic [STEP_W-1:0] r_step, n_step;
    logic              accept;

    assign accept     = r_ready && i_in_valid;
    assign o_in_ready = r_ready;

    // Decode commands from state
    always_comb begin
        o_cmd          = '0;
        o_cmd.accept   = accept;
        o_cmd.update   = (r_state == ST_UPDATE);
        o_cmd.div_step = (r_state == ST_DIVIDE);
        o_cmd.out_load = (r_state == ST_FINISH) && i_status.out_free;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_ready = r_ready;
        n_step  = r_step;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_UPDATE;
                    n_ready = 1'b0;
                end
            end
            ST_UPDATE: begin
                n_state = ST_DIVIDE;
                n_step  = '0;
            end
            ST_DIVIDE: begin
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    n_state = ST_FINISH;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_FINISH: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                    n_ready = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_ready = 1'b1;
            end
        endcase
    end

    // Hold state and registered ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ready <= 1'b1;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
            r_step  <= n_step;
        end
    end

endmodule

`default_nettype wire

[src/lsac_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module lsac_dp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire lsac_pkg::t_ctrl_cmd                 i_cmd,
    output lsac_pkg::t_dp_status                     o_status,
    input  wire logic [lsac_pkg::RAW_W-1:0]          i_raw_sample,
    input  wire logic                                i_cfg_we,
    input  wire logic [lsac_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  wire logic [lsac_pkg::LIMIT_W-1:0]        i_cfg_wdata,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic [lsac_pkg::LUX_W-1:0]               o_current_lux,
    output logic [lsac_pkg::LUX_W-1:0]               o_average_lux,
    output logic [lsac_pkg::STATUS_W-1:0]            o_light_status
);
    import lsac_pkg::*;

    // Limits
    logic [LIMIT_W-1:0] r_low_limit;
    logic [LIMIT_W-1:0] r_high_limit;

    // Ring and running state
    logic [LUX_W-1:0]  r_ring [WINDOW_DEPTH];
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [LUX_W-1:0]  r_lux;
    logic [LUX_W-1:0]  r_old;
    logic              full;

    // Serial divider
    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;
    logic [CNT_W:0]    rem_sh;
    logic [CNT_W:0]    rem_sub;
    logic              q_bit;

    // Output register
    logic                r_out_valid;
    logic [LUX_W-1:0]    r_out_cur;
    logic [LUX_W-1:0]    r_out_avg;
    t_status             r_out_status;
    logic [LUX_W-1:0]    avg;
    logic [LUX_W-1:0]    low_q4;
    logic [LUX_W-1:0]    high_q4;
    t_status             status;

    // Write limits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_limit  <= LOW_LIMIT_RST;
            r_high_limit <= HIGH_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_LOW_LIMIT:  r_low_limit  <= i_cfg_wdata;
                CFG_HIGH_LIMIT: r_high_limit <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Look up lux and read the entry about to be replaced
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_lux <= LUX_ROM[i_raw_sample];
            r_old <= r_ring[r_slot];
        end
    end

    // Write the new entry into the ring
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_ring[r_slot] <= r_lux;
        end
    end

    // Advance ring pointer, fill count and running sum
    always_comb begin
        full    = (r_count == CNT_W'(WINDOW_DEPTH));
        n_sum   = r_sum + SUM_W'(r_lux) - (full ? SUM_W'(r_old) : '0);
        n_count = full ? r_count : r_count + 1'b1;
        n_slot  = (r_slot == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : r_slot + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_count <= '0;
            r_sum   <= '0;
        end else if (i_cmd.update) begin
            r_slot  <= n_slot;
            r_count <= n_count;
            r_sum   <= n_sum;
        end
    end

    // Restoring division, one quotient bit per step
    always_comb begin
        rem_sh  = {r_rem, r_quo[SUM_W-1]};
        rem_sub = rem_sh - {1'b0, r_div};
        q_bit   = (rem_sh >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_quo <= n_sum;
            r_rem <= '0;
            r_div <= n_count;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[SUM_W-2:0], q_bit};
            r_rem <= q_bit ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        end
    end

    // Classify the mean against the limits
    always_comb begin
        avg     = r_quo[LUX_W-1:0];
        low_q4  = {r_low_limit, {FRAC_W{1'b0}}};
        high_q4 = {r_high_limit, {FRAC_W{1'b0}}};
        if (avg >= low_q4 && avg <= high_q4) begin
            status = STATUS_GOOD;
        end else if (avg < low_q4) begin
            status = STATUS_POOR;
        end else begin
            status = STATUS_HIGH;
        end
    end

    // Output register: load when free, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_cur    <= r_lux;
            r_out_avg    <= avg;
            r_out_status <= status;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_current_lux     = r_out_cur;
    assign o_average_lux     = r_out_avg;
    assign o_light_status    = r_out_status;

    // Fill count never passes the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(WINDOW_DEPTH))
        else $error("fill count above ring depth");

    // Until the ring is full the write pointer tracks the fill count
    a_slot_tracks_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count < CNT_W'(WINDOW_DEPTH)) |-> (CNT_W'(r_slot) == r_count))
        else $error("write pointer out of step with fill count");

    // Never overwrite a word still waiting at the output
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("output word overwritten");

    // Divisor is never zero during division
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_div != '0))
        else $error("division by zero fill count");

endmodule

`default_nettype wire

[sim/tb_light_sensor_average_classifier_core.sv]
`timescale 1ns / 1ps

module tb_light_sensor_average_classifier_core;

    import lsac_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 30;
    localparam int REPORT_FIRST  = 10;
    localparam int IDLE_PERCENT  = 7;
    localparam int RAW_TOP       = RAW_COUNT - 1;

    // Mean-lux window and status predictor with its own ring and limits
    class lux_window_scoreboard;

        typedef struct {
            logic [LUX_W-1:0] level;
            logic [LUX_W-1:0] mean;
            t_status          status;
        } t_reading_want;

        logic [LUX_W-1:0]    level_lut [RAW_COUNT];
        longint unsigned     root_factor [17];
        logic [LUX_W-1:0]    ring [WINDOW_DEPTH];
        int unsigned         slot;
        int unsigned         filled;
        longint unsigned     window_total;
        logic [LIMIT_W-1:0]  low_whole;
        logic [LIMIT_W-1:0]  high_whole;
        t_reading_want       want_q [$];
        int unsigned         mismatches;

        function new();
            root_factor[1] = floor_root(64'd1 << 59);
            for (int k = 2; k <= 16; k++) begin
                root_factor[k] = floor_root(root_factor[k-1] << 30);
            end
            for (int r = 0; r < RAW_COUNT; r++) begin
                level_lut[r] = level_of(r);
            end
            slot         = 0;
            filled       = 0;
            window_total = 0;
            low_whole    = LOW_LIMIT_RST;
            high_whole   = HIGH_LIMIT_RST;
            mismatches   = 0;
        endfunction

        // Bitwise search for the largest r with r*r <= v
        function longint unsigned floor_root(longint unsigned v);
            longint unsigned r;
            longint unsigned t;
            r = 0;
            for (int b = 31; b >= 0; b--) begin
                t = r | (64'd1 << b);
                if (t * t <= v) r = t;
            end
            return r;
        endfunction

        // 48200 * raw^-1.53 in Q.4, via fixed-point log2 and a 2^-x product
        function logic [LUX_W-1:0] level_of(int unsigned raw);
            longint unsigned x;
            longint unsigned frac;
            longint unsigned lg;
            longint unsigned ex;
            longint unsigned whole;
            longint unsigned part;
            longint unsigned m;
            longint unsigned prod;
            longint unsigned y;
            int              msb;
            int              sh;
            if (raw == 0) return LUX_MAX;
            msb = 0;
            for (int b = 0; b < RAW_W; b++) begin
                if (raw[b]) msb = b;
            end
            x    = longint'(raw) << (30 - msb);
            frac = 0;
            for (int k = 0; k < 16; k++) begin
                x    = (x * x) >> 30;
                frac = frac << 1;
                if (x >= (64'd2 << 30)) begin
                    frac = frac | 64'd1;
                    x    = x >> 1;
                end
            end
            lg    = (longint'(msb) << 16) | frac;
            ex    = (lg * EXP_NUM + EXP_DEN / 2) / EXP_DEN;
            whole = ex >> 16;
            part  = ex & 64'hFFFF;
            m     = 64'd1 << 30;
            for (int k = 1; k <= 16; k++) begin
                if (part[16-k]) m = (m * root_factor[k] + (64'd1 << 29)) >> 30;
            end
            if (whole > 30) return '0;
            sh   = 30 + int'(whole);
            prod = LUX_SCALE * 64'd16 * m;
            y    = (prod + (64'd1 << (sh - 1))) >> sh;
            if (y > longint'(LUX_MAX)) return LUX_MAX;
            return y[LUX_W-1:0];
        endfunction

        function void set_limit(logic [CFG_ADDR_W-1:0] idx, logic [LIMIT_W-1:0] val);
            if (idx == CFG_LOW_LIMIT) low_whole = val;
            else if (idx == CFG_HIGH_LIMIT) high_whole = val;
        endfunction

        // Advance the ring by one accepted reading and queue its word
        function void note_sample(logic [RAW_W-1:0] raw);
            t_reading_want   w;
            longint unsigned avg;
            longint unsigned low_q4;
            longint unsigned high_q4;
            w.level = level_lut[raw];
            if (filled >= WINDOW_DEPTH) window_total -= ring[slot];
            else filled++;
            ring[slot]    = w.level;
            window_total += w.level;
            slot          = (slot + 1 >= WINDOW_DEPTH) ? 0 : slot + 1;
            avg     = window_total / filled;
            low_q4  = longint'(low_whole) * 16;
            high_q4 = longint'(high_whole) * 16;
            if (avg >= low_q4 && avg <= high_q4) w.status = STATUS_GOOD;
            else if (avg < low_q4) w.status = STATUS_POOR;
            else w.status = STATUS_HIGH;
            w.mean = avg[LUX_W-1:0];
            want_q.push_back(w);
        endfunction

        function void check_word(logic [OUT_TDATA_W-1:0] word);
            t_reading_want         w;
            logic [LUX_W-1:0]      got_level;
            logic [LUX_W-1:0]      got_mean;
            logic [STATUS_W-1:0]   got_status;
            got_level  = word[LUX_W-1:0];
            got_mean   = word[2*LUX_W-1:LUX_W];
            got_status = word[2*LUX_W +: STATUS_W];
            if (want_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_FIRST)
                    $display("unrequested output word %h", word);
                return;
            end
            w = want_q.pop_front();
            if (got_level !== w.level || got_mean !== w.mean || got_status !== w.status) begin
                mismatches++;
                if (mismatches <= REPORT_FIRST)
                    $display("word mismatch (want/got): level %0d/%0d mean %0d/%0d status %0d/%0d",
                             w.level, got_level, w.mean, got_mean, w.status, got_status);
            end
        endfunction

        function int unsigned pending();
            return want_q.size();
        endfunction

    endclass

    logic                        i_clk         = 1'b0;
    logic                        i_rst_n       = 1'b0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [IN_TDATA_W-1:0]       s_axis_tdata  = '0;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]      m_axis_tdata;
    logic                        i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0]       i_cfg_addr    = CFG_LOW_LIMIT;
    logic [LIMIT_W-1:0]          i_cfg_wdata   = '0;

    lux_window_scoreboard        sb = new();
    bit                          steady = 1'b0;
    int                          quiet_cycles = 0;

    logic [RAW_W-1:0] opening_raws [18] = '{
        10'd0, 10'd1, 10'd1023, 10'd2, 10'd3, 10'd512, 10'd511, 10'h2AA, 10'h155,
        10'd1000, 10'd64, 10'd0, 10'd1023, 10'd1, 10'd700, 10'd8, 10'd32, 10'd900
    };

    light_sensor_average_classifier_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Stall the result side at random, except in the steady stretch
    always @(negedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Check every result word as it is taken
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);
    end

    // Stop the run when no word moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Offer one reading, with random gaps, and hold it until taken
    task automatic drive_sample(logic [RAW_W-1:0] raw);
        @(negedge i_clk);
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - RAW_W){1'b0}}, raw};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_sample(raw);
    endtask

    // Drop valid and wait until every queued word has come out
    task automatic finish_burst();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic config_write(logic [CFG_ADDR_W-1:0] idx, logic [LIMIT_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_limit(idx, val);
    endtask

    // Mix of a narrow band (settles the mean), bright, dark and extreme readings
    function automatic logic [RAW_W-1:0] pick_raw(int unsigned band_lo, int unsigned band_hi);
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 4) return '0;
        if (sel < 8) return RAW_W'(RAW_TOP);
        if (sel < 50) return RAW_W'($urandom_range(band_lo, band_hi));
        if (sel < 75) return RAW_W'($urandom_range(1, 64));
        return RAW_W'($urandom_range(0, RAW_TOP));
    endfunction

    task automatic random_burst(int unsigned count);
        int unsigned band_lo;
        int unsigned band_hi;
        band_lo = $urandom_range(0, RAW_TOP);
        band_hi = band_lo + $urandom_range(0, 63);
        if (band_hi > RAW_TOP) band_hi = RAW_TOP;
        repeat (count) drive_sample(pick_raw(band_lo, band_hi));
        finish_burst();
    endtask

    initial begin
        logic [LIMIT_W-1:0] lo;
        logic [LIMIT_W-1:0] hi;

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Extremes of the reading and a partly filled ring under reset limits
        foreach (opening_raws[i]) drive_sample(opening_raws[i]);
        finish_burst();

        // Widest good range
        config_write(CFG_LOW_LIMIT, '0);
        config_write(CFG_HIGH_LIMIT, '1);
        random_burst(150);

        // Crossed limits at the extremes: a run of zero readings reads high
        config_write(CFG_LOW_LIMIT, '1);
        config_write(CFG_HIGH_LIMIT, '0);
        repeat (8) drive_sample('0);
        drive_sample(RAW_W'(RAW_TOP));
        random_burst(100);

        // Steady stretch with no gaps on either side
        steady = 1'b1;
        config_write(CFG_LOW_LIMIT, LIMIT_W'($urandom_range(0, 400)));
        config_write(CFG_HIGH_LIMIT, LIMIT_W'($urandom_range(400, 3000)));
        random_burst(200);
        steady = 1'b0;

        // Random limits, sometimes crossed, sometimes only one updated
        repeat (4) begin
            lo = LIMIT_W'($urandom_range(0, 2500));
            hi = LIMIT_W'($urandom_range(0, 2500));
            if ($urandom_range(0, 99) < 75 && lo > hi) begin
                lo = lo ^ hi;
                hi = lo ^ hi;
                lo = lo ^ hi;
            end
            config_write(CFG_LOW_LIMIT, lo);
            if ($urandom_range(0, 99) < 70) config_write(CFG_HIGH_LIMIT, hi);
            random_burst(130);
        end

        // Moderately crossed limits
        config_write(CFG_LOW_LIMIT, 16'd600);
        config_write(CFG_HIGH_LIMIT, 16'd50);
        random_burst(100);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

[filelist.f]
src/lsac_pkg.sv
src/lsac_ctrl.sv
src/lsac_dp.sv
src/light_sensor_average_classifier_core.sv
sim/tb_light_sensor_average_classifier_core.sv
